[hw/rtl/bpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the button press classifier
// Event codes, register indexes, field widths and the per-key state record.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // field widths
  localparam int unsigned TICK_W  = 12;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned CFG_IDX_W = 4;

  // hold counter saturation value
  localparam logic [TICK_W-1:0] HOLD_MAX = {TICK_W{1'b1}};

  // register reset values
  localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 12'd40;
  localparam logic [TICK_W-1:0] STUCK_TICKS_RST = 12'd3000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_TICKS = 4'd1;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_PRESSED   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_LONG_HELD = 3'd2;
  localparam logic [EVENT_W-1:0] EV_SHORT_REL = 3'd3;
  localparam logic [EVENT_W-1:0] EV_LONG_REL  = 3'd4;

  // debouncer and classifier state
  typedef struct packed {
    logic               level_now;
    logic               level_before;
    logic               press_confirmed;
    logic [EVENT_W-1:0] pending_event;
    logic               fault_latched;
    logic [TICK_W-1:0]  hold_count;
  } bpc_state_t;

  // thresholds from the register file
  typedef struct packed {
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] stuck_ticks;
  } bpc_cfg_t;

endpackage : bpc_pkg
`default_nettype wire

[hw/rtl/bpc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_in_if: sample channel
// One beat carries one sampled key level and the event-take flag.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic valid;
  logic ready;
  logic level;
  logic take_event;

  modport source (output valid, output level, output take_event, input ready);
  modport sink   (input valid, input level, input take_event, output ready);
endinterface : bpc_in_if
`default_nettype wire

[hw/rtl/bpc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_out_if: result channel
// One beat carries the pending event, the stuck flag and the hold count.
// ----------------------------------------------------------------------------
interface bpc_out_if;
  import bpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic               stuck;
  logic [TICK_W-1:0]  hold_ticks;

  modport source (output valid, output event_res, output stuck, output hold_ticks,
                  input ready);
  modport sink   (input valid, input event_res, input stuck, input hold_ticks,
                  output ready);
endinterface : bpc_out_if
`default_nettype wire

[hw/rtl/bpc_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_cfg_if: register write channel
// One beat writes one threshold register selected by index.
// ----------------------------------------------------------------------------
interface bpc_cfg_if;
  import bpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TICK_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : bpc_cfg_if
`default_nettype wire

[hw/rtl/bpc_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_step: next-state logic for one tick
// Shifts the level history, confirms presses, counts hold ticks, classifies
// releases and latches the stuck fault.
// ----------------------------------------------------------------------------
module bpc_step
  import bpc_pkg::*;
(
  input  bpc_state_t state_i,
  input  bpc_cfg_t   cfg_i,
  input  logic       level_i,
  input  logic       take_event_i,
  output bpc_state_t state_o
);

  logic [TICK_W-1:0] hold_inc;

  // saturating increment of the hold counter
  assign hold_inc = (state_i.hold_count == HOLD_MAX) ? state_i.hold_count
                                                     : state_i.hold_count + 1'b1;

  always_comb begin
    state_o = state_i;

    // consumer takes the event before the tick lands
    if (take_event_i) begin
      state_o.pending_event = EV_NONE;
    end

    // level history shifts, unless this tick latches the stuck fault
    state_o.level_before = state_i.level_now;
    state_o.level_now    = level_i;

    if (!state_i.fault_latched) begin
      if (level_i) begin
        // two pressed samples confirm the press
        if (state_i.level_now) begin
          if (!state_i.press_confirmed) begin
            state_o.pending_event = EV_PRESSED;
          end
          state_o.press_confirmed = 1'b1;
        end
        state_o.hold_count = hold_inc;
        // long hold flagged on every tick at or past the threshold
        if (hold_inc >= cfg_i.long_ticks) begin
          state_o.pending_event = EV_LONG_HELD;
        end
        // stuck key: clear history, press and event, keep the count, latch the fault
        if (hold_inc > cfg_i.stuck_ticks) begin
          state_o.level_now       = 1'b0;
          state_o.level_before    = 1'b0;
          state_o.press_confirmed = 1'b0;
          state_o.pending_event   = EV_NONE;
          state_o.fault_latched   = 1'b1;
        end
      end else begin
        state_o.hold_count = '0;
        // two released samples end the press
        if (!state_i.level_now) begin
          if (state_o.pending_event == EV_PRESSED) begin
            state_o.pending_event = EV_SHORT_REL;
          end else if (state_o.pending_event == EV_LONG_HELD) begin
            state_o.pending_event = EV_LONG_REL;
          end
          state_o.press_confirmed = 1'b0;
        end
      end
    end
  end

endmodule : bpc_step
`default_nettype wire

[hw/rtl/button_press_classifier.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_classifier: debounced short/long press classifier
// Takes one key sample per beat and returns the pending event, the stuck
// flag and the hold count after that sample.
//
//   channel   dir  handshake          payload
//   in_bus    in   valid/ready        level, take_event
//   out_bus   out  valid/ready        event_res, stuck, hold_ticks
//   cfg_bus   in   valid/ready        index, data (long_ticks, stuck_ticks)
//
// One beat per clock when out_bus does not stall: the state register is
// updated in the cycle a sample is taken; it is the out_bus result next cycle.
// A new sample is taken whenever the result slot is empty or being drained,
// so a stalled consumer holds the input off only once a result is waiting.
// Synchronous active-low reset clears all state and loads the default
// thresholds (40 and 3000); cfg_bus is always ready.
// ----------------------------------------------------------------------------
module button_press_classifier
  import bpc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  bpc_in_if.sink      in_bus,
  bpc_out_if.source   out_bus,
  bpc_cfg_if.sink     cfg_bus
);

  bpc_state_t state_r;
  bpc_state_t state_nxt;
  bpc_cfg_t   cfg_r;
  logic       out_valid_r;
  logic       in_fire;

  // accept when the result slot is free or being taken this cycle
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_ticks  <= LONG_TICKS_RST;
      cfg_r.stuck_ticks <= STUCK_TICKS_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_LONG_TICKS:  cfg_r.long_ticks  <= cfg_bus.data;
        CFG_STUCK_TICKS: cfg_r.stuck_ticks <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // per-tick update
  bpc_step u_step (
    .state_i      (state_r),
    .cfg_i        (cfg_r),
    .level_i      (in_bus.level),
    .take_event_i (in_bus.take_event),
    .state_o      (state_nxt)
  );

  // state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.event_res  = state_r.pending_event;
  assign out_bus.stuck      = state_r.fault_latched;
  assign out_bus.hold_ticks = state_r.hold_count;

  // fault stays latched until reset
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.fault_latched |=> state_r.fault_latched)
    else $error("stuck fault cleared without reset");

  // hold count frozen while faulted
  a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.fault_latched |=> $stable(state_r.hold_count))
    else $error("hold count moved during stuck fault");

  // pending event stays a defined code
  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending_event <= EV_LONG_REL)
    else $error("pending event out of range");

  // every accepted beat yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted sample produced no result");

  // fault entry leaves an empty event and no confirmed press
  a_fault_clears_event: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !state_r.fault_latched && state_nxt.fault_latched)
      |=> (state_r.pending_event == EV_NONE) && !state_r.press_confirmed)
    else $error("fault entry left event or press set");

endmodule : button_press_classifier
`default_nettype wire
